/* design/hotkey_chord_detector_unit_defines.svh */
// ----------------------------------------------------------------------------
// hotkey chord detector assertion macros
// shared concurrent assertion forms for the checker, sampled on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef HOTKEY_CHORD_DETECTOR_UNIT_DEFINES_SVH
`define HOTKEY_CHORD_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define HCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hcd_pkg.sv */
// ----------------------------------------------------------------------------
// hotkey chord detector package
// key codes, modifier prefix encoding and the match result record
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned ID_W  = 6;
  localparam logic [ID_W-1:0] HOTKEY_MAX = 6'd35;

  localparam logic [KEY_W-1:0] K_CTRL  = 8'h4F;
  localparam logic [KEY_W-1:0] K_SHIFT = 8'h49;
  localparam logic [KEY_W-1:0] K_ALT   = 8'h50;
  localparam logic [KEY_W-1:0] K_WIN   = 8'h3E;
  localparam logic [KEY_W-1:0] K_TAB   = 8'h7B;
  localparam logic [KEY_W-1:0] K_ESC   = 8'h44;
  localparam logic [KEY_W-1:0] K_PGDN  = 8'h48;
  localparam logic [KEY_W-1:0] K_PGUP  = 8'h47;
  localparam logic [KEY_W-1:0] K_LEFT  = 8'h4C;
  localparam logic [KEY_W-1:0] K_UP    = 8'h3A;
  localparam logic [KEY_W-1:0] K_RIGHT = 8'h5A;
  localparam logic [KEY_W-1:0] K_DOWN  = 8'h58;
  localparam logic [KEY_W-1:0] K_DIG1  = 8'h31;
  localparam logic [KEY_W-1:0] K_DIG9  = 8'h39;
  localparam logic [KEY_W-1:0] K_LA    = 8'h61;
  localparam logic [KEY_W-1:0] K_LC    = 8'h63;
  localparam logic [KEY_W-1:0] K_LD    = 8'h64;
  localparam logic [KEY_W-1:0] K_LE    = 8'h65;
  localparam logic [KEY_W-1:0] K_LG    = 8'h67;
  localparam logic [KEY_W-1:0] K_LS    = 8'h73;
  localparam logic [KEY_W-1:0] K_LV    = 8'h76;
  localparam logic [KEY_W-1:0] K_LX    = 8'h78;
  localparam logic [KEY_W-1:0] K_LZ    = 8'h7A;

  typedef enum logic [3:0] {
    PFX_EMPTY      = 4'd0,
    PFX_CTRL       = 4'd1,
    PFX_SHIFT      = 4'd2,
    PFX_ALT        = 4'd3,
    PFX_WIN        = 4'd4,
    PFX_CTRL_ALT   = 4'd5,
    PFX_CTRL_WIN   = 4'd6,
    PFX_CTRL_SHIFT = 4'd7,
    PFX_ALT_CTRL   = 4'd8,
    PFX_WIN_CTRL   = 4'd9,
    PFX_WIN_SHIFT  = 4'd10,
    PFX_SHIFT_CTRL = 4'd11,
    PFX_SHIFT_WIN  = 4'd12
  } prefix_t;

  typedef enum logic [2:0] {
    MOD_NONE,
    MOD_CTRL,
    MOD_SHIFT,
    MOD_ALT,
    MOD_WIN
  } mod_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] id;
    prefix_t         prefix_next;
  } match_t;

  function automatic mod_t mod_of(input logic [KEY_W-1:0] k);
    mod_t m;
    m = MOD_NONE;
    if (k == K_CTRL)  m = MOD_CTRL;
    if (k == K_SHIFT) m = MOD_SHIFT;
    if (k == K_ALT)   m = MOD_ALT;
    if (k == K_WIN)   m = MOD_WIN;
    return m;
  endfunction

endpackage

/* design/hotkey_chord_detector_unit.sv */
// ----------------------------------------------------------------------------
// hotkey chord detector
// recognizes two- and three-key chords in a stream of key codes
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with key_code, one key per request.
// output channel: out_valid / out_stall with hotkey_id, one request per
// completed chord; keys that only set, extend or clear the modifier prefix,
// or are ignored, give nothing.
// a key is matched against the held prefix in the cycle it is accepted;
// its chord number goes to the output register, or to the skid register
// if the receiver stalls. throughput is one key per cycle while in_stall is
// low, set by the single prefix register that each key reads and rewrites.
// if the receiver stalls, one more chord is caught in a skid register and
// in_stall rises until the output drains; keys are never dropped.
// reset clears the prefix to empty and empties the output and skid registers.
// ----------------------------------------------------------------------------
module hotkey_chord_detector_unit import hcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] key_code,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  hotkey_id
);

  prefix_t         prefix;
  match_t          match;
  logic            skid_valid;
  logic [ID_W-1:0] skid_id;
  logic            in_fire;
  logic            out_free;

  hcd_match u_match (
    .prefix   (prefix),
    .key_code (key_code),
    .result   (match)
  );

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix     <= PFX_EMPTY;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        prefix <= match.prefix_next;
      end
      if (skid_valid) begin
        if (out_free) begin
          out_valid  <= 1'b1;
          hotkey_id  <= skid_id;
          skid_valid <= 1'b0;
        end
      end else if (in_fire && match.hit) begin
        if (out_free) begin
          out_valid <= 1'b1;
          hotkey_id <= match.id;
        end else begin
          skid_valid <= 1'b1;
          skid_id    <= match.id;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/hcd_match.sv */
// ----------------------------------------------------------------------------
// hotkey chord match
// next prefix and chord number for one key against the held modifier prefix
// ----------------------------------------------------------------------------
module hcd_match import hcd_pkg::*; (
  input  prefix_t          prefix,
  input  logic [KEY_W-1:0] key_code,
  output match_t           result
);

  mod_t mod;

  assign mod = mod_of(key_code);

  always_comb begin
    result.hit         = 1'b0;
    result.id          = '0;
    result.prefix_next = PFX_EMPTY;
    case (prefix)
      PFX_CTRL: begin
        result.hit = 1'b1;
        if (key_code == K_TAB)                            result.id = 6'd4;
        else if (key_code == K_PGDN)                      result.id = 6'd5;
        else if (key_code == K_PGUP)                      result.id = 6'd6;
        else if (key_code inside {[K_DIG1:K_DIG9]})       result.id = 6'd17;
        else if (key_code == K_LX)                        result.id = 6'd18;
        else if (key_code == K_LC)                        result.id = 6'd19;
        else if (key_code == K_LV)                        result.id = 6'd20;
        else if (key_code == K_LA)                        result.id = 6'd21;
        else if (key_code == K_LZ)                        result.id = 6'd22;
        else if (key_code == K_ESC)                       result.id = 6'd23;
        else begin
          result.hit = 1'b0;
          case (mod)
            MOD_ALT:   result.prefix_next = PFX_CTRL_ALT;
            MOD_WIN:   result.prefix_next = PFX_CTRL_WIN;
            MOD_SHIFT: result.prefix_next = PFX_CTRL_SHIFT;
            default:   result.prefix_next = PFX_EMPTY;
          endcase
        end
      end
      PFX_ALT: begin
        result.hit = 1'b1;
        if (key_code == K_TAB)      result.id = 6'd7;
        else if (key_code == K_ESC) result.id = 6'd9;
        else begin
          result.hit = 1'b0;
          if (mod == MOD_CTRL) result.prefix_next = PFX_ALT_CTRL;
        end
      end
      PFX_WIN: begin
        result.hit = 1'b1;
        if (key_code == K_TAB) result.id = 6'd10;
        else if (key_code inside {K_LEFT, K_UP, K_RIGHT, K_DOWN}) result.id = 6'd14;
        else if (key_code == K_LG) result.id = 6'd28;
        else if (key_code == K_LE) result.id = 6'd29;
        else if (key_code == K_LV) result.id = 6'd30;
        else begin
          result.hit = 1'b0;
          case (mod)
            MOD_CTRL:  result.prefix_next = PFX_WIN_CTRL;
            MOD_SHIFT: result.prefix_next = PFX_WIN_SHIFT;
            default:   result.prefix_next = PFX_EMPTY;
          endcase
        end
      end
      PFX_SHIFT: begin
        // shift alone completes nothing, it only extends or clears the prefix
        case (mod)
          MOD_CTRL: result.prefix_next = PFX_SHIFT_CTRL;
          MOD_WIN:  result.prefix_next = PFX_SHIFT_WIN;
          default:  result.prefix_next = PFX_EMPTY;
        endcase
      end
      PFX_CTRL_ALT: begin
        result.hit = (key_code == K_TAB);
        result.id  = 6'd0;
      end
      PFX_CTRL_WIN: begin
        result.hit = 1'b1;
        if (key_code == K_LD)         result.id = 6'd1;
        else if (key_code == K_LEFT)  result.id = 6'd2;
        else if (key_code == K_RIGHT) result.id = 6'd3;
        else                          result.hit = 1'b0;
      end
      PFX_CTRL_SHIFT: begin
        result.hit = 1'b1;
        if (key_code == K_TAB)      result.id = 6'd16;
        else if (key_code == K_ESC) result.id = 6'd24;
        else                        result.hit = 1'b0;
      end
      PFX_ALT_CTRL: begin
        result.hit = (key_code == K_TAB);
        result.id  = 6'd8;
      end
      PFX_WIN_CTRL: begin
        result.hit = 1'b1;
        if (key_code == K_LD)         result.id = 6'd11;
        else if (key_code == K_LEFT)  result.id = 6'd13;
        else if (key_code == K_RIGHT) result.id = 6'd12;
        else                          result.hit = 1'b0;
      end
      PFX_WIN_SHIFT: begin
        result.hit = 1'b1;
        if (key_code == K_LS)         result.id = 6'd27;
        else if (key_code == K_LEFT)  result.id = 6'd25;
        else if (key_code == K_RIGHT) result.id = 6'd26;
        else                          result.hit = 1'b0;
      end
      PFX_SHIFT_CTRL: begin
        result.hit = 1'b1;
        if (key_code == K_ESC)      result.id = 6'd31;
        else if (key_code == K_TAB) result.id = 6'd32;
        else                        result.hit = 1'b0;
      end
      PFX_SHIFT_WIN: begin
        result.hit = 1'b1;
        if (key_code == K_RIGHT)     result.id = 6'd33;
        else if (key_code == K_LEFT) result.id = 6'd34;
        else if (key_code == K_LS)   result.id = 6'd35;
        else                         result.hit = 1'b0;
      end
      default: begin
        // empty prefix (and unused codes): store a modifier, drop anything else
        case (mod)
          MOD_CTRL:  result.prefix_next = PFX_CTRL;
          MOD_SHIFT: result.prefix_next = PFX_SHIFT;
          MOD_ALT:   result.prefix_next = PFX_ALT;
          MOD_WIN:   result.prefix_next = PFX_WIN;
          default:   result.prefix_next = PFX_EMPTY;
        endcase
      end
    endcase
  end

endmodule

/* design/hcd_checker.sv */
// ----------------------------------------------------------------------------
// hotkey chord detector checker
// port-level checks on the output channel and the skid back-pressure
// ----------------------------------------------------------------------------
`include "hotkey_chord_detector_unit_defines.svh"

module hcd_checker import hcd_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [ID_W-1:0] hotkey_id
);

  `HCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hotkey_id), "output request changed while stalled")
  `HCD_ASSERT_NOW(a_id_range, out_valid, hotkey_id <= HOTKEY_MAX, "hotkey number out of range")
  // back-pressure only with a full, stalled output
  `HCD_ASSERT_NOW(a_stall_full, in_stall, out_valid, "input stalled with empty output")
  `HCD_ASSERT_NOW(a_stall_cause, in_stall && !$past(in_stall), $past(out_valid && out_stall), "input stall without a stalled output")
  `HCD_ASSERT_NOW(a_reset_empty, $fell(rst), !out_valid && !in_stall, "channels not empty after reset")

endmodule

bind hotkey_chord_detector_unit hcd_checker u_hcd_checker (.*);
